@@ rtl/core/bilinear_image_rotate_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear image rotate block
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_ROTATE_MACROS_SVH
`define BILINEAR_IMAGE_ROTATE_MACROS_SVH

// same-cycle implication
`define BIR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bilinear_image_rotate: assertion failed");

// next-cycle implication
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bilinear_image_rotate: assertion failed");

`endif

@@ rtl/core/bir_pkg.sv @@
// ----------------------------------------------------------------------------
// bir_pkg
// Types and constants shared by the bilinear image rotate block.
// ----------------------------------------------------------------------------
package bir_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COLOR_MODE   = 3'd2,
    REG_CENTER_X     = 3'd3,
    REG_CENTER_Y     = 3'd4,
    REG_COS          = 3'd5,
    REG_SIN          = 3'd6
  } reg_idx_e;

  localparam int XP_W   = 31;  // source point, 2^-18 pixel units
  localparam int PROD_W = 29;  // 13b offset times 16b factor
  localparam int X0_W   = 13;  // integer part of source point
  localparam int WGT_W  = 17;  // product of two 9-bit weights
  localparam int ACC_W  = 25;
  localparam logic [1:0] CREDITS = 2'd2;  // output register plus skid

  typedef struct packed {
    op_e                      op;
    logic [7:0]               px;
    logic [7:0]               py;
    logic [23:0]              rgb;
    logic signed [X0_W-1:0]   x0;
    logic signed [X0_W-1:0]   y0;
    logic [7:0]               bx;
    logic [7:0]               by;
  } item_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             in_img;
    logic [WGT_W-1:0] wgt;
  } beat_t;

endpackage

@@ rtl/core/bir_map.sv @@
// ----------------------------------------------------------------------------
// bir_map
// Two-stage coordinate mapping: offset products, then sum and floor split.
// ----------------------------------------------------------------------------
module bir_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [7:0]          pixel_x_i,
  input  logic [7:0]          pixel_y_i,
  input  logic [23:0]         rgb_i,
  input  logic                color_mode_i,
  input  logic [11:0]         center_x_i,
  input  logic [11:0]         center_y_i,
  input  logic signed [15:0]  cos_i,
  input  logic signed [15:0]  sin_i,
  output logic                item_valid_o,
  output bir_pkg::item_t      item_o,
  input  logic                take_i
);

  logic s1_valid_q, s1_valid_d;
  logic s2_valid_q, s2_valid_d;
  logic s1_free, s2_free, s1_move, accept;

  bir_pkg::op_e s1_op_q;
  logic [7:0]   s1_px_q, s1_py_q;
  logic [23:0]  s1_rgb_q;
  logic signed [bir_pkg::PROD_W-1:0] s1_xc_q, s1_ys_q, s1_xs_q, s1_yc_q;
  logic signed [bir_pkg::PROD_W-1:0] xc_d, ys_d, xs_d, yc_d;
  logic signed [12:0] dx, dy;
  logic signed [bir_pkg::XP_W-1:0] xp, yp, cxs, cys;
  bir_pkg::item_t item_q, item_d;

  assign s2_free    = !s2_valid_q || take_i;
  assign s1_move    = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  assign dx   = $signed({1'b0, pixel_x_i, 4'b0000}) - $signed({1'b0, center_x_i});
  assign dy   = $signed({1'b0, pixel_y_i, 4'b0000}) - $signed({1'b0, center_y_i});
  assign xc_d = dx * cos_i;
  assign ys_d = dy * sin_i;
  assign xs_d = dx * sin_i;
  assign yc_d = dy * cos_i;

  assign cxs = $signed({5'b00000, center_x_i, 14'd0});
  assign cys = $signed({5'b00000, center_y_i, 14'd0});
  assign xp  = cxs + bir_pkg::XP_W'(s1_xc_q) - bir_pkg::XP_W'(s1_ys_q);
  assign yp  = cys + bir_pkg::XP_W'(s1_xs_q) + bir_pkg::XP_W'(s1_yc_q);

  always_comb begin
    item_d     = item_q;
    item_d.op  = s1_op_q;
    item_d.px  = s1_px_q;
    item_d.py  = s1_py_q;
    item_d.rgb = s1_rgb_q;
    // two's complement top bits are the floor
    item_d.x0  = xp[bir_pkg::XP_W-1:18];
    item_d.y0  = yp[bir_pkg::XP_W-1:18];
    item_d.bx  = xp[17:10];
    item_d.by  = yp[17:10];
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
    end else if (take_i) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= bir_pkg::op_e'(op_i);
      s1_px_q  <= pixel_x_i;
      s1_py_q  <= pixel_y_i;
      s1_rgb_q <= color_mode_i ? rgb_i : {16'd0, rgb_i[7:0]};
      s1_xc_q  <= xc_d;
      s1_ys_q  <= ys_d;
      s1_xs_q  <= xs_d;
      s1_yc_q  <= yc_d;
    end
    if (s1_move) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = s2_valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/core/bir_frame.sv @@
// ----------------------------------------------------------------------------
// bir_frame
// Single-port frame store, 24-bit pixels, registered read data.
// ----------------------------------------------------------------------------
module bir_frame #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [23:0]       wdata_i,
  output logic [23:0]       rdata_o
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bir_blend.sv @@
// ----------------------------------------------------------------------------
// bir_blend
// Weighted accumulate of the four neighbors, rounding, output register+skid.
// ----------------------------------------------------------------------------
module bir_blend (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           beat_valid_i,
  input  bir_pkg::beat_t beat_i,
  input  logic [23:0]    rdata_i,
  input  logic           color_mode_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_red_o,
  output logic [7:0]     out_green_o,
  output logic [7:0]     out_blue_o
);

  logic [bir_pkg::ACC_W-1:0] acc_q [3];
  logic [bir_pkg::ACC_W-1:0] sum [3];
  logic [bir_pkg::ACC_W-1:0] rnd [3];
  logic [23:0] pix, res;
  logic        done, pop;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [23:0] out_q, out_d, skid_q, skid_d;

  assign pix  = beat_i.in_img ? rdata_i : 24'd0;
  assign done = beat_valid_i && beat_i.last;
  assign pop  = out_valid_q && !out_stall_i;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = (beat_i.first ? '0 : acc_q[ch]) + beat_i.wgt * pix[8*ch +: 8];
      rnd[ch] = sum[ch] + bir_pkg::ACC_W'(32768);
    end
    res[7:0]   = rnd[0][23:16];
    res[15:8]  = color_mode_i ? rnd[1][23:16] : 8'd0;
    res[23:16] = color_mode_i ? rnd[2][23:16] : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (beat_valid_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc_q[ch] <= sum[ch];
      end
    end
  end

  // skid keeps the newer result; upstream credits keep it from overflowing
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = done;
        skid_d       = res;
      end else begin
        out_valid_d = done;
        out_d       = res;
      end
    end else if (done) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[7:0];
  assign out_green_o = out_q[15:8];
  assign out_blue_o  = out_q[23:16];

endmodule

@@ rtl/core/bilinear_image_rotate.sv @@
// ----------------------------------------------------------------------------
// bilinear_image_rotate
// Frame store with rotated, bilinearly interpolated pixel readout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o): op_i = 0 stores one pixel at
//   (pixel_x_i, pixel_y_i); op_i = 1 requests the rotated pixel there.
//   Output channel (out_valid_o / out_stall_i): one transaction per read
//   request, in request order; writes give none.
//   The APB port sets size, color mode, center and cos/sin; write it only
//   while no request is in flight.
// Path: a read passes the mapping stages, then the fetch sequencer, the frame
//   store read with its beat tag, and the blend into its output register.
// Port use: reads are paced by the four neighbor fetches through the single
//   frame store port; a write makes one access of that port.
// Reset: control state clears, registers take their defaults. The frame
//   store is not cleared; unwritten pixels must not be read.
// Stall: an output register plus a one-entry skid hold results; a read waits
//   for one of two credits, and in_stall_o rises as the pipeline backs up.
// ----------------------------------------------------------------------------
`include "bilinear_image_rotate_macros.svh"

module bilinear_image_rotate #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  pixel_x_i,
  input  logic [7:0]  pixel_y_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = 13;  // effective size, capped at MAX_WIDTH / MAX_HEIGHT
  localparam int CW     = 14;  // neighbor coordinate, signed

  // configuration registers
  logic [8:0]         cfg_w_q, cfg_h_q;
  logic               cfg_mode_q;
  logic [11:0]        cfg_cx_q, cfg_cy_q;
  logic signed [15:0] cfg_cos_q, cfg_sin_q;
  logic               cfg_wr;
  bir_pkg::reg_idx_e  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = bir_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= 9'd256;
      cfg_h_q    <= 9'd256;
      cfg_mode_q <= 1'b1;
      cfg_cx_q   <= 12'd2048;
      cfg_cy_q   <= 12'd2048;
      cfg_cos_q  <= 16'sd16384;
      cfg_sin_q  <= 16'sd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bir_pkg::REG_IMAGE_WIDTH:  cfg_w_q    <= pwdata[8:0];
        bir_pkg::REG_IMAGE_HEIGHT: cfg_h_q    <= pwdata[8:0];
        bir_pkg::REG_COLOR_MODE:   cfg_mode_q <= pwdata[0];
        bir_pkg::REG_CENTER_X:     cfg_cx_q   <= pwdata[11:0];
        bir_pkg::REG_CENTER_Y:     cfg_cy_q   <= pwdata[11:0];
        bir_pkg::REG_COS:          cfg_cos_q  <= pwdata[15:0];
        bir_pkg::REG_SIN:          cfg_sin_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bir_pkg::REG_IMAGE_WIDTH:  prdata = 32'(cfg_w_q);
      bir_pkg::REG_IMAGE_HEIGHT: prdata = 32'(cfg_h_q);
      bir_pkg::REG_COLOR_MODE:   prdata = 32'(cfg_mode_q);
      bir_pkg::REG_CENTER_X:     prdata = 32'(cfg_cx_q);
      bir_pkg::REG_CENTER_Y:     prdata = 32'(cfg_cy_q);
      bir_pkg::REG_COS:          prdata = {16'd0, cfg_cos_q};
      bir_pkg::REG_SIN:          prdata = {16'd0, cfg_sin_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // coordinate mapping pipeline
  logic           item_valid, load;
  bir_pkg::item_t item;

  bir_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .rgb_i        ({in_blue_i, in_green_i, in_red_i}),
    .color_mode_i (cfg_mode_q),
    .center_x_i   (cfg_cx_q),
    .center_y_i   (cfg_cy_q),
    .cos_i        (cfg_cos_q),
    .sin_i        (cfg_sin_q),
    .item_valid_o (item_valid),
    .item_o       (item),
    .take_i       (load)
  );

  // fetch sequencer: owns the frame store port, at most one access per cycle while it holds an item
  logic           f_valid_q, f_valid_d;
  logic [1:0]     f_cnt_q, f_cnt_d;
  bir_pkg::item_t f_item_q;
  logic           f_done, f_free, f_read;
  logic [1:0]     credit_q, credit_d;
  logic           out_pop;
  logic [SW-1:0]  w_eff, h_eff;
  logic [CW-1:0]  nx, ny;
  logic           in_img, in_store;
  logic [8:0]     wx, wy;
  logic [ADDR_W-1:0] rd_addr, wr_addr, mem_addr;
  logic           mem_en;
  logic [23:0]    mem_rdata;

  assign w_eff = (32'(cfg_w_q) > MAX_WIDTH)  ? SW'(MAX_WIDTH)  : SW'(cfg_w_q);
  assign h_eff = (32'(cfg_h_q) > MAX_HEIGHT) ? SW'(MAX_HEIGHT) : SW'(cfg_h_q);

  assign f_read = f_item_q.op == bir_pkg::OP_READ;
  assign f_done = f_valid_q && (!f_read || f_cnt_q == 2'd3);
  assign f_free = !f_valid_q || f_done;
  assign load   = item_valid && f_free &&
                  (item.op == bir_pkg::OP_WRITE || credit_q != 2'd0);

  assign nx = CW'(f_item_q.x0) + CW'(f_cnt_q[0]);
  assign ny = CW'(f_item_q.y0) + CW'(f_cnt_q[1]);
  assign in_img = !nx[CW-1] && !ny[CW-1] &&
                  (nx[SW-1:0] < w_eff) && (ny[SW-1:0] < h_eff);
  assign in_store = (32'(f_item_q.px) < MAX_WIDTH) && (32'(f_item_q.py) < MAX_HEIGHT);

  assign rd_addr = ADDR_W'(32'(ny[SW-1:0]) * MAX_WIDTH + 32'(nx[SW-1:0]));
  assign wr_addr = ADDR_W'(32'(f_item_q.py) * MAX_WIDTH + 32'(f_item_q.px));
  assign mem_addr = f_read ? rd_addr : wr_addr;
  assign mem_en   = f_valid_q && (f_read ? in_img : in_store);

  assign wx = f_cnt_q[0] ? {1'b0, f_item_q.bx} : 9'd256 - {1'b0, f_item_q.bx};
  assign wy = f_cnt_q[1] ? {1'b0, f_item_q.by} : 9'd256 - {1'b0, f_item_q.by};

  always_comb begin
    f_valid_d = f_valid_q;
    f_cnt_d   = f_cnt_q;
    if (f_valid_q && f_read) begin
      f_cnt_d = f_cnt_q + 2'd1;
    end
    if (load) begin
      f_valid_d = 1'b1;
      f_cnt_d   = 2'd0;
    end else if (f_done) begin
      f_valid_d = 1'b0;
      f_cnt_d   = 2'd0;
    end
    credit_d = credit_q - 2'((load && item.op == bir_pkg::OP_READ) ? 1 : 0)
                        + 2'(out_pop ? 1 : 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      f_cnt_q   <= 2'd0;
      credit_q  <= bir_pkg::CREDITS;
    end else begin
      f_valid_q <= f_valid_d;
      f_cnt_q   <= f_cnt_d;
      credit_q  <= credit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      f_item_q <= item;
    end
  end

  bir_frame #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_frame (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (!f_read),
    .addr_i  (mem_addr),
    .wdata_i (f_item_q.rgb),
    .rdata_o (mem_rdata)
  );

  // beat tag travels alongside the memory read
  logic          beat_valid_q;
  bir_pkg::beat_t beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid_q <= 1'b0;
    end else begin
      beat_valid_q <= f_valid_q && f_read;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q.first  <= f_cnt_q == 2'd0;
    beat_q.last   <= f_cnt_q == 2'd3;
    beat_q.in_img <= in_img;
    beat_q.wgt    <= bir_pkg::WGT_W'({8'd0, wx} * {8'd0, wy});
  end

  bir_blend u_blend (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_valid_i (beat_valid_q),
    .beat_i       (beat_q),
    .rdata_i      (mem_rdata),
    .color_mode_i (cfg_mode_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o)
  );

  assign out_pop = out_valid_o && !out_stall_i;

  `BIR_ASSERT_IMPLIES(a_credit_range, 1'b1, credit_q <= bir_pkg::CREDITS)
  `BIR_ASSERT_IMPLIES(a_out_holds_credit, out_valid_o, credit_q != bir_pkg::CREDITS)
  `BIR_ASSERT_IMPLIES(a_idle_cnt_zero, !f_valid_q, f_cnt_q == 2'd0)
  `BIR_ASSERT_IMPLIES(a_last_after_first, beat_valid_q && beat_q.last, $past(beat_valid_q, 3) && $past(beat_q.first, 3))
  `BIR_ASSERT_NEXT(a_read_stays, f_valid_q && f_read && f_cnt_q != 2'd3, f_valid_q)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Bilinear image rotate testbench
// Loads pixels into the frame store, requests rotated pixels under a range
// of register settings and compares every result with a local predictor.
// Sender and receiver idle at random outside bursts and the final phases; reads never touch unwritten pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int STORE_DIM   = 256;
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE      = 12;
  localparam int PHASE_ITEMS = 53;
  localparam logic [4:0] UNUSED_ADDR = 5'd28;

  // predicted frame store, register copy and expected rotated pixels
  class rotate_scoreboard;
    bit [23:0]          pixels[STORE_DIM*STORE_DIM];
    bit                 written[STORE_DIM*STORE_DIM];
    bit [8:0]           width, height;
    bit                 color;
    bit [11:0]          cx, cy;
    logic signed [15:0] cos_f, sin_f;
    bit [23:0]          expected_rgb[$];
    int                 errors;
    int                 compared;

    function new();
      width = 9'd256; height = 9'd256; color = 1'b1;
      cx = 12'd2048; cy = 12'd2048; cos_f = 16'sd16384; sin_f = 16'sd0;
    endfunction

    function void write_reg(bir_pkg::reg_idx_e idx, logic [31:0] v);
      case (idx)
        bir_pkg::REG_IMAGE_WIDTH:  width  = v[8:0];
        bir_pkg::REG_IMAGE_HEIGHT: height = v[8:0];
        bir_pkg::REG_COLOR_MODE:   color  = v[0];
        bir_pkg::REG_CENTER_X:     cx     = v[11:0];
        bir_pkg::REG_CENTER_Y:     cy     = v[11:0];
        bir_pkg::REG_COS:          cos_f  = v[15:0];
        bir_pkg::REG_SIN:          sin_f  = v[15:0];
        default: ;
      endcase
    endfunction

    // source point: floor in whole pixels plus 8-bit fraction
    function void source_point(logic [7:0] x, logic [7:0] y, output longint x0,
                               output longint y0, output int bx, output int by);
      longint dx, dy, xp, yp;
      dx = longint'(x) * 16 - longint'(cx);
      dy = longint'(y) * 16 - longint'(cy);
      xp = longint'(cx) * 16384 + dx * longint'(cos_f) - dy * longint'(sin_f);
      yp = longint'(cy) * 16384 + dx * longint'(sin_f) + dy * longint'(cos_f);
      x0 = xp >>> 18;
      y0 = yp >>> 18;
      bx = int'((xp >>> 10) & 255);
      by = int'((yp >>> 10) & 255);
    endfunction

    function bit inside_img(longint x, longint y);
      longint w, h;
      w = (width > STORE_DIM) ? STORE_DIM : width;
      h = (height > STORE_DIM) ? STORE_DIM : height;
      return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    // a read may go out only if no in-image neighbor is still unwritten
    function bit readable(logic [7:0] x, logic [7:0] y);
      longint x0, y0;
      int bx, by;
      source_point(x, y, x0, y0, bx, by);
      for (int j = 0; j < 2; j++)
        for (int i = 0; i < 2; i++)
          if (inside_img(x0 + i, y0 + j) && !written[(y0 + j) * STORE_DIM + x0 + i])
            return 1'b0;
      return 1'b1;
    endfunction

    function bit [23:0] neighbor(longint x, longint y);
      if (!inside_img(x, y)) return 24'd0;
      return pixels[y * STORE_DIM + x];
    endfunction

    function bit [23:0] rotated_pixel(logic [7:0] x, logic [7:0] y);
      longint x0, y0, total;
      int bx, by;
      longint wgt[4];
      bit [23:0] nb[4];
      bit [23:0] res;
      source_point(x, y, x0, y0, bx, by);
      wgt[0] = (256 - bx) * (256 - by);
      wgt[1] = bx * (256 - by);
      wgt[2] = (256 - bx) * by;
      wgt[3] = bx * by;
      nb[0] = neighbor(x0, y0);
      nb[1] = neighbor(x0 + 1, y0);
      nb[2] = neighbor(x0, y0 + 1);
      nb[3] = neighbor(x0 + 1, y0 + 1);
      res = '0;
      for (int ch = 0; ch < (color ? 3 : 1); ch++) begin
        total = 0;
        for (int k = 0; k < 4; k++) total += wgt[k] * nb[k][ch*8 +: 8];
        total = (total + 32768) >> 16;
        res[ch*8 +: 8] = (total > 255) ? 8'd255 : total[7:0];
      end
      return res;
    endfunction

    function void note_input(bir_pkg::op_e op, logic [7:0] x, logic [7:0] y,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      if (op == bir_pkg::OP_WRITE) begin
        pixels[y * STORE_DIM + x] = color ? {b, g, r} : {16'd0, r};
        written[y * STORE_DIM + x] = 1'b1;
      end else begin
        expected_rgb.push_back(rotated_pixel(x, y));
      end
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      bit [23:0] exp_rgb;
      compared++;
      if (expected_rgb.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result r=%0d g=%0d b=%0d", r, g, b);
        return;
      end
      exp_rgb = expected_rgb.pop_front();
      if ({b, g, r} !== exp_rgb) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   exp_rgb[7:0], exp_rgb[15:8], exp_rgb[23:16], r, g, b);
      end
    endfunction
  endclass

  typedef struct {
    int w, h, mode, cx, cy, cos_f, sin_f;
  } setting_t;

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid_i, in_stall_o, op_i;
  logic [7:0]  pixel_x_i, pixel_y_i, in_red_i, in_green_i, in_blue_i;
  logic        out_valid_o, out_stall_i;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;

  rotate_scoreboard sb = new();
  int  send_pct, recv_pct;
  bit  burst;
  int  idle_cycles;
  int  n_writes, n_reads, n_phases;

  bilinear_image_rotate dut (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receiver: check each result transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_red_o, out_green_o, out_blue_o);
      out_stall_i <= !burst && ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("bilinear_image_rotate test failed");
        $finish;
      end
    end
  end

  task automatic apb_write(logic [4:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
    if (addr != UNUSED_ADDR) sb.write_reg(bir_pkg::reg_idx_e'(addr[4:2]), data);
  endtask

  task automatic push_item(bir_pkg::op_e op, logic [7:0] x, logic [7:0] y,
                           logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!burst && $urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; op_i <= op; pixel_x_i <= x; pixel_y_i <= y;
    in_red_i <= r; in_green_i <= g; in_blue_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(op, x, y, r, g, b);
    if (op == bir_pkg::OP_WRITE) n_writes++;
    else n_reads++;
    if ((n_writes + n_reads) % 40 == 0) burst = ($urandom_range(2) == 0);
  endtask

  task automatic write_pixel(int x, int y);
    push_item(bir_pkg::OP_WRITE, x[7:0], y[7:0], $urandom_range(255), $urandom_range(255),
              $urandom_range(255));
  endtask

  task automatic try_read(int x, int y, ref int sent);
    if (sb.readable(x[7:0], y[7:0])) begin
      push_item(bir_pkg::OP_READ, x[7:0], y[7:0], $urandom_range(255), $urandom_range(255),
                $urandom_range(255));
      sent++;
    end
  endtask

  // all results in, then let trailing writes finish before touching registers
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_rgb.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic int clip(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic run_phase(setting_t s);
    int cxp, cyp, sent, tries, pick;
    cxp = clip(s.cx / 16);
    cyp = clip(s.cy / 16);
    sent = 0;
    tries = 0;
    drain();
    apb_write({bir_pkg::REG_IMAGE_WIDTH, 2'b00}, s.w);
    apb_write({bir_pkg::REG_IMAGE_HEIGHT, 2'b00}, s.h);
    apb_write({bir_pkg::REG_COLOR_MODE, 2'b00}, s.mode);
    apb_write({bir_pkg::REG_CENTER_X, 2'b00}, s.cx);
    apb_write({bir_pkg::REG_CENTER_Y, 2'b00}, s.cy);
    apb_write({bir_pkg::REG_COS, 2'b00}, s.cos_f);
    apb_write({bir_pkg::REG_SIN, 2'b00}, s.sin_f);
    n_phases++;
    for (int y = clip(cyp - 4); y <= clip(cyp + 4); y++)
      for (int x = clip(cxp - 4); x <= clip(cxp + 4); x++)
        write_pixel(x, y);
    while (sent < PHASE_ITEMS && tries < 8 * PHASE_ITEMS) begin
      tries++;
      pick = $urandom_range(99);
      if (pick < 70)
        try_read(clip(cxp + $urandom_range(12) - 6), clip(cyp + $urandom_range(12) - 6), sent);
      else if (pick < 85) begin
        write_pixel(clip(cxp + $urandom_range(10) - 5), clip(cyp + $urandom_range(10) - 5));
        sent++;
      end else if (pick < 95) begin
        write_pixel($urandom_range(255), $urandom_range(255));
        sent++;
      end else
        try_read($urandom_range(255), $urandom_range(255), sent);
    end
  endtask

  initial begin
    setting_t plan[$];
    setting_t s;
    int dummy;
    rst_ni <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_valid_i <= 1'b0; op_i <= bir_pkg::OP_WRITE; pixel_x_i <= '0; pixel_y_i <= '0;
    in_red_i <= '0; in_green_i <= '0; in_blue_i <= '0;
    out_stall_i <= 1'b0;
    send_pct = 17; recv_pct = 73; burst = 1'b0;
    idle_cycles = 0; n_writes = 0; n_reads = 0; n_phases = 0; dummy = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corners at the extremes, identity readout at reset settings
    push_item(bir_pkg::OP_WRITE, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    push_item(bir_pkg::OP_WRITE, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    push_item(bir_pkg::OP_WRITE, 8'd0, 8'd1, 8'd255, 8'd0, 8'd255);
    push_item(bir_pkg::OP_WRITE, 8'd1, 8'd1, 8'd0, 8'd255, 8'd0);
    push_item(bir_pkg::OP_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    push_item(bir_pkg::OP_WRITE, 8'd254, 8'd255, 8'd170, 8'd85, 8'd1);
    push_item(bir_pkg::OP_WRITE, 8'd255, 8'd254, 8'd128, 8'd127, 8'd254);
    push_item(bir_pkg::OP_WRITE, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0);
    try_read(0, 0, dummy);
    try_read(255, 255, dummy);
    try_read(254, 254, dummy);
    try_read(254, 255, dummy);
    // unknown register address is ignored
    drain();
    apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    try_read(0, 0, dummy);
    try_read(255, 255, dummy);

    plan.push_back('{256, 256, 1, 2048, 2048, 16384, 0});
    plan.push_back('{16, 16, 1, 128, 128, 11585, 11585});
    plan.push_back('{1, 1, 0, 0, 0, -16384, 0});
    plan.push_back('{256, 256, 1, 4095, 4095, 0, 16384});
    plan.push_back('{0, 5, 1, 800, 800, 16384, 0});
    plan.push_back('{300, 511, 0, 2000, 1000, -16384, -16384});
    plan.push_back('{37, 23, 1, 300, 200, 32767, -32768});
    plan.push_back('{200, 64, 1, 1600, 512, 15137, -6270});
    plan.push_back('{256, 256, 0, 0, 4095, -11585, 11585});
    plan.push_back('{8, 8, 1, 64, 64, 16384, 0});
    for (int i = 0; i < 5; i++) begin
      s.w = $urandom_range(1, 256); s.h = $urandom_range(1, 256);
      s.mode = $urandom_range(1); s.cx = $urandom_range(4095); s.cy = $urandom_range(4095);
      s.cos_f = $signed(16'($urandom)); s.sin_f = $signed(16'($urandom));
      if (i < 3) begin
        s.cos_f = $urandom_range(32768) - 16384;
        s.sin_f = $urandom_range(32768) - 16384;
      end
      plan.push_back(s);
    end

    foreach (plan[p]) begin
      if (p < 5) begin send_pct = 17; recv_pct = 73; end
      else if (p < 10) begin send_pct = 73; recv_pct = 17; end
      else begin send_pct = 0; recv_pct = 0; end
      run_phase(plan[p]);
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("covered %0d pixel writes and %0d rotated reads over %0d register settings",
             n_writes, n_reads, n_phases);
    $display("%0d results compared, %0d failures", sb.compared, sb.errors);
    if (sb.errors == 0 && sb.expected_rgb.size() == 0)
      $display("bilinear_image_rotate test passed");
    else
      $display("bilinear_image_rotate test failed");
    $finish;
  end

endmodule
